// ===== sv/bounded_list_store_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bounded list store
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LIST_STORE_MACROS_SVH
`define BOUNDED_LIST_STORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled while reset is asserted
`define BLS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, disabled while reset is asserted
`define BLS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BLS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define BLS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== sv/bls_pkg.sv =====
// ----------------------------------------------------------------------------
// bls_pkg
// Sizes, operation codes and status codes of the bounded list store.
// ----------------------------------------------------------------------------
package bls_pkg;

  // storage geometry
  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  // transaction field widths
  localparam int MODE_W   = 3;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_INSERT = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_GET    = 3'd4,
    MODE_FIND   = 3'd5,
    MODE_CLEAR  = 3'd6
  } mode_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

endpackage

// ===== sv/bls_ram.sv =====
// ----------------------------------------------------------------------------
// bls_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/bounded_list_store.sv =====
// ----------------------------------------------------------------------------
// bounded_list_store
// Ordered list of signed 32-bit words with fixed capacity, one op per command.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge with start high and busy low;
//   in_mode selects push, pop, insert, remove, get, find or clear, with
//   in_position and in_element as operands. Exactly one result follows,
//   shown for a single cycle with out_valid high: out_value_out,
//   out_status (ok, empty, bad index / not found, full) and out_count_out.
//   busy is low again in the cycle the result is shown, so a new command can
//   be taken at that same edge.
// Sequence from acceptance to result:
//   push, clear, unused mode and any refused command: shown in the cycle
//   after acceptance. pop, get: RAM read, then S_RD_WAIT, then the result.
//   insert, remove: S_SHIFT_UP / S_SHIFT_DN move the words between position
//   and the end of the list, then the result. find: S_SCAN reads from index
//   0 up and stops at the first match, or after the last word (with no read
//   when the list is empty). The element store has one read and one write
//   port, so shifts and searches move one word per cycle.
// Reset clears the item count and the sequencer; stored words are not
//   cleared and are only read below the count. The receiver cannot stall:
//   each result is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
`include "bounded_list_store_macros.svh"

module bounded_list_store (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [bls_pkg::MODE_W-1:0]          in_mode,
  input  logic [bls_pkg::POS_W-1:0]           in_position,
  input  logic signed [bls_pkg::DATA_W-1:0]   in_element,
  output logic                                out_valid,
  output logic signed [bls_pkg::DATA_W-1:0]   out_value_out,
  output logic [bls_pkg::STATUS_W-1:0]        out_status,
  output logic [bls_pkg::CNT_W-1:0]           out_count_out
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_SCAN
  } state_t;

  state_t                            state_r, state_nxt;
  logic [bls_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [bls_pkg::CNT_W-1:0]         idx_r, idx_nxt;
  logic [bls_pkg::ADDR_W-1:0]        last_r, last_nxt;
  logic                              pend_r, pend_nxt;
  logic [bls_pkg::POS_W-1:0]         pos_r, pos_nxt;
  logic [bls_pkg::DATA_W-1:0]        elem_r, elem_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic signed [bls_pkg::DATA_W-1:0] out_value_r, out_value_nxt;
  bls_pkg::status_t                  out_status_r, out_status_nxt;
  logic [bls_pkg::CNT_W-1:0]         out_count_r, out_count_nxt;

  // RAM port signals
  logic                              ram_we;
  logic [bls_pkg::ADDR_W-1:0]        ram_waddr;
  logic [bls_pkg::DATA_W-1:0]        ram_wdata;
  logic [bls_pkg::ADDR_W-1:0]        ram_raddr;
  logic [bls_pkg::DATA_W-1:0]        ram_rdata;

  // shared index arithmetic
  logic [bls_pkg::CNT_W-1:0]         cnt_dec;
  logic [bls_pkg::CNT_W-1:0]         idx_dec;
  logic [bls_pkg::CNT_W-1:0]         pos_ext;
  logic [bls_pkg::CNT_W-1:0]         in_pos_ext;

  assign cnt_dec    = cnt_r - bls_pkg::CNT_W'(1);
  assign idx_dec    = idx_r - bls_pkg::CNT_W'(1);
  assign pos_ext    = bls_pkg::CNT_W'(pos_r);
  assign in_pos_ext = bls_pkg::CNT_W'(in_position);

  // element store
  bls_ram #(
    .WIDTH (bls_pkg::DATA_W),
    .DEPTH (bls_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer next-state logic
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    last_nxt       = last_r;
    pend_nxt       = pend_r;
    pos_nxt        = pos_r;
    elem_nxt       = elem_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = elem_r;
    ram_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          pos_nxt        = in_position;
          elem_nxt       = in_element;
          out_value_nxt  = '0;
          out_status_nxt = bls_pkg::ST_OK;
          pend_nxt       = 1'b0;
          case (in_mode)
            bls_pkg::MODE_PUSH: begin
              out_valid_nxt = 1'b1;
              if (cnt_r >= bls_pkg::CAP_CNT) begin
                out_status_nxt = bls_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_r[bls_pkg::ADDR_W-1:0];
                ram_wdata = in_element;
                cnt_nxt   = cnt_r + bls_pkg::CNT_W'(1);
              end
            end
            bls_pkg::MODE_POP: begin
              if (cnt_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = bls_pkg::ST_EMPTY;
              end else begin
                cnt_nxt   = cnt_dec;
                ram_raddr = cnt_dec[bls_pkg::ADDR_W-1:0];
                state_nxt = S_RD_WAIT;
              end
            end
            bls_pkg::MODE_GET: begin
              if (cnt_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = bls_pkg::ST_EMPTY;
              end else if (in_pos_ext >= cnt_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = bls_pkg::ST_BAD;
              end else begin
                ram_raddr = in_pos_ext[bls_pkg::ADDR_W-1:0];
                state_nxt = S_RD_WAIT;
              end
            end
            bls_pkg::MODE_INSERT: begin
              if (in_pos_ext >= cnt_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = bls_pkg::ST_BAD;
              end else if (cnt_r >= bls_pkg::CAP_CNT) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = bls_pkg::ST_FULL;
              end else begin
                idx_nxt   = cnt_r;
                state_nxt = S_SHIFT_UP;
              end
            end
            bls_pkg::MODE_REMOVE: begin
              if (cnt_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = bls_pkg::ST_EMPTY;
              end else if (in_pos_ext >= cnt_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = bls_pkg::ST_BAD;
              end else begin
                idx_nxt   = in_pos_ext;
                state_nxt = S_SHIFT_DN;
              end
            end
            bls_pkg::MODE_FIND: begin
              idx_nxt   = '0;
              state_nxt = S_SCAN;
            end
            bls_pkg::MODE_CLEAR: begin
              out_valid_nxt = 1'b1;
              cnt_nxt       = '0;
            end
            default: begin
              // unused mode: no operation
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      // read data for pop and get
      S_RD_WAIT: begin
        out_value_nxt = ram_rdata;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      // insert: read word i-1, write it to i on the next cycle, top down
      S_SHIFT_UP: begin
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = last_r + bls_pkg::ADDR_W'(1);
          ram_wdata = ram_rdata;
        end
        if (idx_r > pos_ext) begin
          ram_raddr = idx_dec[bls_pkg::ADDR_W-1:0];
          last_nxt  = idx_dec[bls_pkg::ADDR_W-1:0];
          pend_nxt  = 1'b1;
          idx_nxt   = idx_dec;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          ram_we        = 1'b1;
          ram_waddr     = pos_r;
          ram_wdata     = elem_r;
          cnt_nxt       = cnt_r + bls_pkg::CNT_W'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // remove: first read is the result, later ones move down one place
      S_SHIFT_DN: begin
        if (pend_r) begin
          if (last_r == pos_r) begin
            out_value_nxt = ram_rdata;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = last_r - bls_pkg::ADDR_W'(1);
            ram_wdata = ram_rdata;
          end
        end
        if (idx_r < cnt_r) begin
          ram_raddr = idx_r[bls_pkg::ADDR_W-1:0];
          last_nxt  = idx_r[bls_pkg::ADDR_W-1:0];
          pend_nxt  = 1'b1;
          idx_nxt   = idx_r + bls_pkg::CNT_W'(1);
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          cnt_nxt       = cnt_dec;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // find: compare each word read against the key, lowest index first
      S_SCAN: begin
        if (pend_r && (ram_rdata == elem_r)) begin
          out_value_nxt = {{(bls_pkg::DATA_W - bls_pkg::ADDR_W){1'b0}}, last_r};
          pend_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (idx_r < cnt_r) begin
          ram_raddr = idx_r[bls_pkg::ADDR_W-1:0];
          last_nxt  = idx_r[bls_pkg::ADDR_W-1:0];
          pend_nxt  = 1'b1;
          idx_nxt   = idx_r + bls_pkg::CNT_W'(1);
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          out_status_nxt = bls_pkg::ST_BAD;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // reported count is the count after the operation
    out_count_nxt = out_valid_nxt ? cnt_nxt : out_count_r;
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    last_r       <= last_nxt;
    pos_r        <= pos_nxt;
    elem_r       <= elem_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_status    = out_status_r;
  assign out_count_out = out_count_r;

  // checks
  `BLS_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= bls_pkg::CAP_CNT, "count above capacity")
  `BLS_ASSERT_NXT(a_start_seen, clk, rst_n, start && !busy, busy || out_valid, "command lost")
  `BLS_ASSERT_IMP(a_out_idle, clk, rst_n, out_valid, !busy, "result shown while busy")
  `BLS_ASSERT_IMP(a_full_cnt, clk, rst_n, out_valid && out_status_r == bls_pkg::ST_FULL, out_count_out == bls_pkg::CAP_CNT, "full status below capacity")
  `BLS_ASSERT_IMP(a_out_cnt, clk, rst_n, out_valid, out_count_out == cnt_r, "reported count differs from held count")

endmodule

// ===== tb/list_op_checker.sv =====
// ----------------------------------------------------------------------------
// list_op_checker
// Watches the command and result channels of the bounded list store, keeps
// its own copy of the list, predicts one result per accepted command and
// compares each result field by field, oldest prediction first.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module list_op_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic [bls_pkg::MODE_W-1:0]        in_mode,
  input  logic [bls_pkg::POS_W-1:0]         in_position,
  input  logic signed [bls_pkg::DATA_W-1:0] in_element,
  input  logic                              out_valid,
  input  logic signed [bls_pkg::DATA_W-1:0] out_value_out,
  input  logic [bls_pkg::STATUS_W-1:0]      out_status,
  input  logic [bls_pkg::CNT_W-1:0]         out_count_out,
  output int                                fail_count,
  output int                                results_owed
);

  typedef struct packed {
    logic signed [bls_pkg::DATA_W-1:0] value;
    bls_pkg::status_t                  status;
    logic [bls_pkg::CNT_W-1:0]         count;
  } list_result_t;

  // shadow copy of the list
  logic signed [bls_pkg::DATA_W-1:0] shadow_words [bls_pkg::CAPACITY];
  int                                shadow_count;

  list_result_t awaited_results [$];
  int           mismatches;

  // apply one command to the shadow list and return the result it yields
  function automatic list_result_t apply_list_op(logic [bls_pkg::MODE_W-1:0] op_code,
                                                 logic [bls_pkg::POS_W-1:0] pos,
                                                 logic signed [bls_pkg::DATA_W-1:0] elem);
    list_result_t r;
    int           idx;
    bit           hit;
    r.value  = '0;
    r.status = bls_pkg::ST_OK;
    hit      = 1'b0;
    idx      = int'(pos);
    case (op_code)
      bls_pkg::MODE_PUSH: begin
        if (shadow_count >= bls_pkg::CAPACITY) begin
          r.status = bls_pkg::ST_FULL;
        end else begin
          shadow_words[shadow_count] = elem;
          shadow_count++;
        end
      end
      bls_pkg::MODE_POP: begin
        if (shadow_count == 0) begin
          r.status = bls_pkg::ST_EMPTY;
        end else begin
          shadow_count--;
          r.value = shadow_words[shadow_count];
        end
      end
      bls_pkg::MODE_INSERT: begin
        // insert needs an existing slot and a free one
        if (idx >= shadow_count) begin
          r.status = bls_pkg::ST_BAD;
        end else if (shadow_count >= bls_pkg::CAPACITY) begin
          r.status = bls_pkg::ST_FULL;
        end else begin
          for (int i = shadow_count; i > idx; i--)
            shadow_words[i] = shadow_words[i-1];
          shadow_words[idx] = elem;
          shadow_count++;
        end
      end
      bls_pkg::MODE_REMOVE: begin
        if (shadow_count == 0) begin
          r.status = bls_pkg::ST_EMPTY;
        end else if (idx >= shadow_count) begin
          r.status = bls_pkg::ST_BAD;
        end else begin
          r.value = shadow_words[idx];
          for (int i = idx; i + 1 < shadow_count; i++)
            shadow_words[i] = shadow_words[i+1];
          shadow_count--;
        end
      end
      bls_pkg::MODE_GET: begin
        if (shadow_count == 0) begin
          r.status = bls_pkg::ST_EMPTY;
        end else if (idx >= shadow_count) begin
          r.status = bls_pkg::ST_BAD;
        end else begin
          r.value = shadow_words[idx];
        end
      end
      bls_pkg::MODE_FIND: begin
        // lowest matching index wins
        r.status = bls_pkg::ST_BAD;
        for (int i = 0; i < shadow_count; i++) begin
          if (!hit && shadow_words[i] == elem) begin
            hit      = 1'b1;
            r.value  = i;
            r.status = bls_pkg::ST_OK;
          end
        end
      end
      bls_pkg::MODE_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
        // unused code: no change
      end
    endcase
    r.count = bls_pkg::CNT_W'(shadow_count);
    return r;
  endfunction

  // compare results first, then queue the prediction for a new transaction
  always @(posedge clk) begin
    list_result_t exp_r;
    if (!rst_n) begin
      shadow_count = 0;
      awaited_results.delete();
    end else begin
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected: value %0d status %0d count %0d",
                   $time, out_value_out, out_status, out_count_out);
        end else begin
          exp_r = awaited_results.pop_front();
          if (out_value_out !== exp_r.value) begin
            mismatches++;
            $display("%0t: value mismatch: expected %0d, actual %0d",
                     $time, exp_r.value, out_value_out);
          end
          if (out_status !== exp_r.status) begin
            mismatches++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, exp_r.status, out_status);
          end
          if (out_count_out !== exp_r.count) begin
            mismatches++;
            $display("%0t: count mismatch: expected %0d, actual %0d",
                     $time, exp_r.count, out_count_out);
          end
        end
      end
      if (start && !busy)
        awaited_results.push_back(apply_list_op(in_mode, in_position, in_element));
    end
    fail_count   <= mismatches;
    results_owed <= awaited_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random list commands into the bounded list store with
// random idle gaps, and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  // code outside the defined operations; the block treats it as a no-op
  localparam logic [bls_pkg::MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam int RANDOM_OPS  = 700;
  localparam int QUIET_LIMIT = 500;
  localparam int DRAIN_WAIT  = 24;

  logic                              clk;
  logic                              rst_n       = 1'b0;
  logic                              start       = 1'b0;
  logic [bls_pkg::MODE_W-1:0]        in_mode     = bls_pkg::MODE_PUSH;
  logic [bls_pkg::POS_W-1:0]         in_position = '0;
  logic signed [bls_pkg::DATA_W-1:0] in_element  = '0;
  logic                              busy;
  logic                              out_valid;
  logic signed [bls_pkg::DATA_W-1:0] out_value_out;
  logic [bls_pkg::STATUS_W-1:0]      out_status;
  logic [bls_pkg::CNT_W-1:0]         out_count_out;

  int fail_count;
  int results_owed;

  bit                                allow_gaps = 1'b1;
  int                                seen_count = 0;
  int                                quiet_cycles = 0;
  logic signed [bls_pkg::DATA_W-1:0] recent_elems [8];
  logic signed [bls_pkg::DATA_W-1:0] fill_elems [16];

  bounded_list_store dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_position   (in_position),
    .in_element    (in_element),
    .out_valid     (out_valid),
    .out_value_out (out_value_out),
    .out_status    (out_status),
    .out_count_out (out_count_out)
  );

  list_op_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_position   (in_position),
    .in_element    (in_element),
    .out_valid     (out_valid),
    .out_value_out (out_value_out),
    .out_status    (out_status),
    .out_count_out (out_count_out),
    .fail_count    (fail_count),
    .results_owed  (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // last count reported, used to steer positions toward valid indexes
  always @(posedge clk) begin
    if (out_valid)
      seen_count <= int'(out_count_out);
  end

  // watchdog: ends the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** bounded_list_store: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one command, with optional idle cycles first, until accepted
  task automatic send_op(input logic [bls_pkg::MODE_W-1:0] op_code,
                         input logic [bls_pkg::POS_W-1:0] pos,
                         input logic signed [bls_pkg::DATA_W-1:0] elem);
    while (allow_gaps && $urandom_range(0, 99) < 18) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_mode     <= op_code;
    in_position <= pos;
    in_element  <= elem;
    do @(posedge clk); while (busy);
  endtask

  // operation mix; fill phases grow the list, drain phases shrink it
  function automatic logic [bls_pkg::MODE_W-1:0] pick_mode(bit filling);
    int roll;
    roll = $urandom_range(0, 99);
    if (filling) begin
      if (roll < 35)      return bls_pkg::MODE_PUSH;
      else if (roll < 55) return bls_pkg::MODE_INSERT;
      else if (roll < 70) return bls_pkg::MODE_FIND;
      else if (roll < 80) return bls_pkg::MODE_GET;
      else if (roll < 89) return bls_pkg::MODE_REMOVE;
      else if (roll < 97) return bls_pkg::MODE_POP;
      else                return bls_pkg::MODE_CLEAR;
    end else begin
      if (roll < 22)      return bls_pkg::MODE_POP;
      else if (roll < 46) return bls_pkg::MODE_REMOVE;
      else if (roll < 61) return bls_pkg::MODE_PUSH;
      else if (roll < 71) return bls_pkg::MODE_INSERT;
      else if (roll < 82) return bls_pkg::MODE_GET;
      else if (roll < 97) return bls_pkg::MODE_FIND;
      else                return bls_pkg::MODE_CLEAR;
    end
  endfunction

  // mostly a valid index of the current list, sometimes anything
  function automatic logic [bls_pkg::POS_W-1:0] pick_position();
    int hi;
    hi = (seen_count == 0) ? 0 : seen_count - 1;
    if (hi > 15)
      hi = 15;
    if ($urandom_range(0, 99) < 75)
      return bls_pkg::POS_W'($urandom_range(0, hi));
    return bls_pkg::POS_W'($urandom_range(0, 15));
  endfunction

  // corner values, recently stored values (so finds hit), or any word
  function automatic logic signed [bls_pkg::DATA_W-1:0] pick_element();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      case ($urandom_range(0, 4))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return '0;
        3:       return -1;
        default: return 1;
      endcase
    end
    if (roll < 55)
      return recent_elems[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  initial begin
    logic [bls_pkg::MODE_W-1:0]        op_code;
    logic signed [bls_pkg::DATA_W-1:0] elem;

    foreach (recent_elems[i])
      recent_elems[i] = $urandom;
    fill_elems[0]  = 32'sh8000_0000;
    fill_elems[1]  = 32'sh7fff_ffff;
    fill_elems[2]  = '0;
    fill_elems[3]  = -1;
    fill_elems[4]  = 32'sh5555_5555;
    fill_elems[5]  = 32'shaaaa_aaaa;
    for (int i = 6; i < 15; i++)
      fill_elems[i] = $urandom;
    fill_elems[15] = 32'sh1234_5678;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: every read-type op is refused, insert has no valid slot
    send_op(bls_pkg::MODE_POP,    4'd0,  '0);
    send_op(bls_pkg::MODE_GET,    4'd0,  '0);
    send_op(bls_pkg::MODE_REMOVE, 4'd0,  '0);
    send_op(bls_pkg::MODE_INSERT, 4'd0,  32'sh0000_0011);
    send_op(bls_pkg::MODE_FIND,   4'd0,  '0);
    send_op(MODE_UNUSED,          4'd15, -1);

    // fill to capacity, then push and insert into a full list
    for (int i = 0; i < 16; i++)
      send_op(bls_pkg::MODE_PUSH, 4'd0, fill_elems[i]);
    send_op(bls_pkg::MODE_PUSH,   4'd0,  32'sh0000_0022);
    send_op(bls_pkg::MODE_INSERT, 4'd7,  32'sh0000_0033);

    // full-length shift, long search, index past the end, then clear
    send_op(bls_pkg::MODE_REMOVE, 4'd0,  '0);
    send_op(bls_pkg::MODE_FIND,   4'd0,  fill_elems[15]);
    send_op(bls_pkg::MODE_GET,    4'd15, '0);
    send_op(bls_pkg::MODE_CLEAR,  4'd0,  '0);

    // random part: alternating fill and drain phases, one stretch without gaps
    for (int n = 0; n < RANDOM_OPS; n++) begin
      allow_gaps = !(n >= 300 && n < 420);
      op_code = pick_mode(((n / 40) % 2) == 0);
      elem    = pick_element();
      if (op_code == bls_pkg::MODE_PUSH || op_code == bls_pkg::MODE_INSERT)
        recent_elems[$urandom_range(0, 7)] = elem;
      send_op(op_code, pick_position(), elem);
    end

    // drain: no more commands, wait for outstanding results
    start <= 1'b0;
    @(posedge clk);
    while (results_owed != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0 && results_owed == 0)
      $display("** bounded_list_store: PASSED **");
    else
      $display("** bounded_list_store: FAILED **");
    $finish;
  end

endmodule
